// ----- src/time_of_day_clock_with_alarm_table_unit_macros.svh -----
// Assertion macros shared by the time-of-day clock RTL.
`ifndef TIME_OF_DAY_CLOCK_WITH_ALARM_TABLE_UNIT_MACROS_SVH
`define TIME_OF_DAY_CLOCK_WITH_ALARM_TABLE_UNIT_MACROS_SVH
`ifndef SYNTHESIS
`define TODC_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);
`define TODC_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);
`else
`define TODC_ASSERT_IMP(label, clk, rst_n, ante, cons, msg)
`define TODC_ASSERT_NXT(label, clk, rst_n, ante, cons, msg)
`endif
`endif

// ----- src/todc_pkg.sv -----
// Package with types, codes and constants of the time-of-day clock with alarm table.
`timescale 1ns / 1ps
`default_nettype none
package todc_pkg;

  localparam int ALARM_SLOTS_DEF = 10;

  localparam logic [2:0] ACT_TICK     = 3'd0;
  localparam logic [2:0] ACT_SET_TIME = 3'd1;
  localparam logic [2:0] ACT_ADD      = 3'd2;
  localparam logic [2:0] ACT_ENABLE   = 3'd3;
  localparam logic [2:0] ACT_CLEAR    = 3'd4;
  localparam logic [2:0] ACT_ACK      = 3'd5;

  localparam logic [4:0] HOURS_PER_DAY = 5'd24;
  localparam logic [4:0] HOUR_LAST     = 5'd23;
  localparam logic [5:0] MIN_PER_HOUR  = 6'd60;
  localparam logic [5:0] MIN_LAST      = 6'd59;
  localparam logic [5:0] SEC_LAST      = 6'd59;

  typedef struct packed {
    logic [2:0] action;
    logic [4:0] set_hour;
    logic [5:0] set_minute;
    logic       enable_value;
  } in_item_t;

  typedef struct packed {
    logic [4:0] hour_now;
    logic [5:0] minute_now;
    logic [5:0] second_now;
    logic       alarm_fired;
    logic [3:0] fired_index;
    logic       ringing_now;
    logic [3:0] alarms_used;
    logic       heartbeat;
  } out_item_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_EXEC,
    ST_SCAN,
    ST_DONE
  } ctrl_state_t;

  typedef struct packed {
    logic load_item;
    logic exec;
    logic scan_step;
    logic fire;
    logic load_out;
  } ctrl_cmd_t;

  typedef struct packed {
    logic scan_req;
    logic hit;
    logic last;
  } ctrl_stat_t;

endpackage
`default_nettype wire

// ----- src/time_of_day_clock_with_alarm_table_unit.sv -----
// Top level of the time-of-day clock with alarm table.
// Flow: an accepted item goes through ST_EXEC, then ST_SCAN while it scans alarm entries (1 to
// ALARM_SLOTS of them) on a tick that reaches second zero while alarms are enabled, none rings
// and entries are in use, then ST_DONE, which loads the result register.
// The block takes no new item until the last one's result is loaded; a stalled result holds the input.
// Reset: synchronous, active low; clears the time, alarm count and ringing, enables alarms.
`timescale 1ns / 1ps
`default_nettype none
`include "time_of_day_clock_with_alarm_table_unit_macros.svh"
module time_of_day_clock_with_alarm_table_unit
  import todc_pkg::*;
#(
  parameter int ALARM_SLOTS = ALARM_SLOTS_DEF
) (
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      in_valid,
  output      logic      in_stall,
  input  wire in_item_t  in_item,
  output      logic      out_valid,
  input  wire logic      out_stall,
  output      out_item_t out_item
);

  ctrl_cmd_t  cmd;
  ctrl_stat_t stat;

  todc_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .stat      (stat),
    .cmd       (cmd)
  );

  todc_dp #(
    .ALARM_SLOTS (ALARM_SLOTS)
  ) u_dp (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_item  (in_item),
    .cmd      (cmd),
    .stat     (stat),
    .out_item (out_item)
  );

  `TODC_ASSERT_NXT(a_busy_after_accept, clk, rst_n, in_valid && !in_stall, in_stall, "block took an item but did not go busy")
  `TODC_ASSERT_IMP(a_fired_rings, clk, rst_n, out_valid && out_item.alarm_fired, out_item.ringing_now, "alarm fired without ringing")
  `TODC_ASSERT_IMP(a_no_fire_zero_index, clk, rst_n, out_valid && !out_item.alarm_fired, out_item.fired_index == 4'd0, "fired index set without an alarm")
  `TODC_ASSERT_IMP(a_single_cmd, clk, rst_n, 1'b1, $onehot0({cmd.load_item, cmd.exec, cmd.scan_step, cmd.fire, cmd.load_out}), "controller issued conflicting commands")

endmodule
`default_nettype wire

// ----- src/todc_dp.sv -----
// Datapath of the time-of-day clock: time counters, alarm memory, scan and result register.
`timescale 1ns / 1ps
`default_nettype none
module todc_dp
  import todc_pkg::*;
#(
  parameter int ALARM_SLOTS = ALARM_SLOTS_DEF
) (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire in_item_t   in_item,
  input  wire ctrl_cmd_t  cmd,
  output      ctrl_stat_t stat,
  output      out_item_t  out_item
);

  localparam int CNT_W = $clog2(ALARM_SLOTS + 1);
  localparam int IDX_W = (ALARM_SLOTS > 1) ? $clog2(ALARM_SLOTS) : 1;

  in_item_t         item_r;
  logic [4:0]       hour_r, hour_nxt;
  logic [5:0]       minute_r, minute_nxt;
  logic [5:0]       second_r, second_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic             alarm_on_r, alarm_on_nxt;
  logic             ringing_r, ringing_nxt;
  logic             fired_r, fired_nxt;
  logic [IDX_W-1:0] fidx_r, fidx_nxt;
  logic             beat_r, beat_nxt;
  logic [IDX_W-1:0] scan_idx_r, scan_idx_nxt;
  logic [10:0]      rd_data_r;
  out_item_t        out_r;

  logic [10:0]      mem [ALARM_SLOTS];
  logic             we;
  logic [IDX_W-1:0] wr_addr;
  logic [4:0]       hr_mod;
  logic [5:0]       mn_mod;
  logic [7:0]       fidx_ext;
  logic [7:0]       count_ext;

  assign hr_mod = (item_r.set_hour >= HOURS_PER_DAY) ? (item_r.set_hour - HOURS_PER_DAY)
                                                     : item_r.set_hour;
  assign mn_mod = (item_r.set_minute >= MIN_PER_HOUR) ? (item_r.set_minute - MIN_PER_HOUR)
                                                      : item_r.set_minute;

  assign stat.scan_req = (item_r.action == ACT_TICK) && (second_r == SEC_LAST) &&
                         alarm_on_r && !ringing_r && (count_r != '0);
  assign stat.hit  = (rd_data_r[10:6] == hour_r) && (rd_data_r[5:0] == minute_r);
  assign stat.last = (CNT_W'(scan_idx_r) + CNT_W'(1)) >= count_r;

  always_comb begin
    hour_nxt     = hour_r;
    minute_nxt   = minute_r;
    second_nxt   = second_r;
    count_nxt    = count_r;
    alarm_on_nxt = alarm_on_r;
    ringing_nxt  = ringing_r;
    fired_nxt    = fired_r;
    fidx_nxt     = fidx_r;
    beat_nxt     = beat_r;
    scan_idx_nxt = scan_idx_r;
    we           = 1'b0;
    wr_addr      = '0;
    if (cmd.exec) begin
      fired_nxt    = 1'b0;
      fidx_nxt     = '0;
      beat_nxt     = 1'b0;
      scan_idx_nxt = '0;
      case (item_r.action)
        ACT_TICK: begin
          beat_nxt = ~second_r[0];
          if (second_r == SEC_LAST) begin
            second_nxt = '0;
            if (minute_r == MIN_LAST) begin
              minute_nxt = '0;
              hour_nxt   = (hour_r == HOUR_LAST) ? '0 : hour_r + 5'd1;
            end else begin
              minute_nxt = minute_r + 6'd1;
            end
          end else begin
            second_nxt = second_r + 6'd1;
          end
        end
        ACT_SET_TIME: begin
          hour_nxt   = hr_mod;
          minute_nxt = mn_mod;
          second_nxt = '0;
        end
        ACT_ADD: begin
          we = 1'b1;
          if (count_r >= CNT_W'(ALARM_SLOTS)) begin
            wr_addr = '0;
          end else begin
            wr_addr   = count_r[IDX_W-1:0];
            count_nxt = count_r + CNT_W'(1);
          end
        end
        ACT_ENABLE: begin
          alarm_on_nxt = item_r.enable_value;
        end
        ACT_CLEAR: begin
          count_nxt = '0;
        end
        ACT_ACK: begin
          ringing_nxt = 1'b0;
        end
        default: begin
        end
      endcase
    end
    if (cmd.scan_step) begin
      scan_idx_nxt = scan_idx_r + IDX_W'(1);
    end
    if (cmd.fire) begin
      ringing_nxt = 1'b1;
      fired_nxt   = 1'b1;
      fidx_nxt    = scan_idx_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hour_r     <= '0;
      minute_r   <= '0;
      second_r   <= '0;
      count_r    <= '0;
      alarm_on_r <= 1'b1;
      ringing_r  <= 1'b0;
    end else begin
      hour_r     <= hour_nxt;
      minute_r   <= minute_nxt;
      second_r   <= second_nxt;
      count_r    <= count_nxt;
      alarm_on_r <= alarm_on_nxt;
      ringing_r  <= ringing_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_item) begin
      item_r <= in_item;
    end
    fired_r    <= fired_nxt;
    fidx_r     <= fidx_nxt;
    beat_r     <= beat_nxt;
    scan_idx_r <= scan_idx_nxt;
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem[wr_addr] <= {hr_mod, mn_mod};
    end
    rd_data_r <= mem[scan_idx_nxt];
  end

  assign fidx_ext  = 8'(fidx_r);
  assign count_ext = 8'(count_r);

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      out_r.hour_now    <= hour_r;
      out_r.minute_now  <= minute_r;
      out_r.second_now  <= second_r;
      out_r.alarm_fired <= fired_r;
      out_r.fired_index <= fidx_ext[3:0];
      out_r.ringing_now <= ringing_r;
      out_r.alarms_used <= count_ext[3:0];
      out_r.heartbeat   <= beat_r;
    end
  end

  assign out_item = out_r;

endmodule
`default_nettype wire

// ----- src/todc_ctrl.sv -----
// Controller state machine of the time-of-day clock: item sequencing, alarm scan and output valid.
`timescale 1ns / 1ps
`default_nettype none
module todc_ctrl
  import todc_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_valid,
  output      logic       in_stall,
  output      logic       out_valid,
  input  wire logic       out_stall,
  input  wire ctrl_stat_t stat,
  output      ctrl_cmd_t  cmd
);

  ctrl_state_t state_r, state_nxt;
  logic        out_valid_r, out_valid_nxt;
  logic        out_free;

  assign out_free = !out_valid_r || !out_stall;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          state_nxt = ST_EXEC;
        end
      end
      ST_EXEC: begin
        state_nxt = stat.scan_req ? ST_SCAN : ST_DONE;
      end
      ST_SCAN: begin
        if (stat.hit || stat.last) begin
          state_nxt = ST_DONE;
        end
      end
      ST_DONE: begin
        if (out_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    cmd = '0;
    case (state_r)
      ST_IDLE: begin
        cmd.load_item = in_valid;
      end
      ST_EXEC: begin
        cmd.exec = 1'b1;
      end
      ST_SCAN: begin
        cmd.fire      = stat.hit;
        cmd.scan_step = !stat.hit && !stat.last;
      end
      ST_DONE: begin
        cmd.load_out = out_free;
      end
      default: begin
      end
    endcase
  end

  assign out_valid_nxt = cmd.load_out ? 1'b1 : (out_valid_r && out_stall);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign in_stall  = (state_r != ST_IDLE);
  assign out_valid = out_valid_r;

endmodule
`default_nettype wire

// ----- verif/tb_time_of_day_clock_with_alarm_table_unit.sv -----
// Testbench for the time-of-day clock with alarm table: directed rows, alarm scenes, noise.
`timescale 1ns / 1ps
module tb_time_of_day_clock_with_alarm_table_unit;
  import todc_pkg::*;

  localparam logic [2:0] ACT_SPARE6 = 3'd6;
  localparam logic [2:0] ACT_SPARE7 = 3'd7;
  localparam int N_DIR = 25;
  localparam int N_RAND = 1000;

  typedef struct {
    in_item_t  it;
    bit        typed;
    out_item_t res;
  } dir_row_t;

  logic      clk = 1'b0;
  logic      rst_n;
  logic      in_valid;
  logic      in_stall;
  in_item_t  in_item;
  logic      out_valid;
  logic      out_stall;
  out_item_t out_item;

  logic [4:0]  hour_q;
  logic [5:0]  min_q;
  logic [5:0]  sec_q;
  logic [10:0] alarm_tab [ALARM_SLOTS_DEF];
  logic [3:0]  alarm_cnt;
  logic        alarms_en;
  logic        ring_q;

  out_item_t pending_readings[$];
  dir_row_t  dir_tab [N_DIR];
  int        items_sent = 0;
  int        readings_seen = 0;
  int        alarms_rung = 0;
  int        errs = 0;

  always #2 clk = ~clk;

  time_of_day_clock_with_alarm_table_unit i_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_item  (in_item),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_item (out_item)
  );

  function automatic in_item_t mk_in(logic [2:0] a, logic [4:0] h, logic [5:0] m, logic e);
    in_item_t r;
    r.action = a;
    r.set_hour = h;
    r.set_minute = m;
    r.enable_value = e;
    return r;
  endfunction

  function automatic out_item_t mk_out(logic [4:0] h, logic [5:0] m, logic [5:0] s,
                                       logic f, logic [3:0] idx, logic ring,
                                       logic [3:0] used, logic hb);
    out_item_t r;
    r.hour_now = h;
    r.minute_now = m;
    r.second_now = s;
    r.alarm_fired = f;
    r.fired_index = idx;
    r.ringing_now = ring;
    r.alarms_used = used;
    r.heartbeat = hb;
    return r;
  endfunction

  function automatic out_item_t clock_step(in_item_t it);
    out_item_t  r;
    logic [4:0] hr;
    logic [5:0] mn;
    r = '0;
    hr = it.set_hour % HOURS_PER_DAY;
    mn = it.set_minute % MIN_PER_HOUR;
    case (it.action)
      ACT_TICK: begin
        r.heartbeat = ~sec_q[0];
        if (sec_q == SEC_LAST) begin
          sec_q = '0;
          if (min_q == MIN_LAST) begin
            min_q = '0;
            hour_q = (hour_q == HOUR_LAST) ? 5'd0 : hour_q + 5'd1;
          end else begin
            min_q = min_q + 6'd1;
          end
        end else begin
          sec_q = sec_q + 6'd1;
        end
        if (sec_q == 6'd0 && alarms_en && !ring_q) begin
          for (int i = 0; i < int'(alarm_cnt); i++) begin
            if (alarm_tab[i] == {hour_q, min_q}) begin
              ring_q = 1'b1;
              r.alarm_fired = 1'b1;
              r.fired_index = 4'(i);
              break;
            end
          end
        end
      end
      ACT_SET_TIME: begin
        hour_q = hr;
        min_q = mn;
        sec_q = '0;
      end
      ACT_ADD: begin
        if (alarm_cnt >= ALARM_SLOTS_DEF) begin
          alarm_tab[0] = {hr, mn};
        end else begin
          alarm_tab[alarm_cnt] = {hr, mn};
          alarm_cnt = alarm_cnt + 4'd1;
        end
      end
      ACT_ENABLE: alarms_en = it.enable_value;
      ACT_CLEAR: alarm_cnt = '0;
      ACT_ACK: ring_q = 1'b0;
      default: ;
    endcase
    r.hour_now = hour_q;
    r.minute_now = min_q;
    r.second_now = sec_q;
    r.ringing_now = ring_q;
    r.alarms_used = alarm_cnt;
    return r;
  endfunction

  task automatic put_item(input in_item_t it, input bit typed = 1'b0,
                          input out_item_t res = '0);
    out_item_t pred;
    int        gap;
    gap = ((items_sent % 256) >= 200) ? 0 : $urandom_range(0, 15);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_item <= it;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    pred = clock_step(it);
    pending_readings.push_back(typed ? res : pred);
    items_sent++;
  endtask

  task automatic put_noise();
    logic [2:0] a;
    a = ($urandom_range(0, 1) == 0) ? ACT_TICK : 3'($urandom_range(0, 7));
    put_item(mk_in(a, 5'($urandom_range(0, 31)), 6'($urandom_range(0, 63)),
                   1'($urandom_range(0, 1))));
  endtask

  // One alarm scene: load the table around a target time, park the clock one minute
  // before it and tick through the minute so the search runs on second zero.
  task automatic run_alarm_scene();
    int         n;
    int         k;
    logic [4:0] th;
    logic [5:0] tm;
    logic [4:0] ph;
    logic [5:0] pm;
    if ($urandom_range(0, 9) < 7) put_item(mk_in(ACT_CLEAR, 0, 0, 0));
    th = 5'($urandom_range(0, 23));
    tm = ($urandom_range(0, 6) == 0) ? 6'd0 : 6'($urandom_range(0, 59));
    if ($urandom_range(0, 19) == 0) th = '0;
    n = $urandom_range(1, 12);
    k = $urandom_range(0, n - 1);
    for (int i = 0; i < n; i++) begin
      if (i == k || $urandom_range(0, 5) == 0) begin
        put_item(mk_in(ACT_ADD, th, tm, 1'($urandom_range(0, 1))));
      end else begin
        put_item(mk_in(ACT_ADD, 5'($urandom_range(0, 31)), 6'($urandom_range(0, 63)),
                       1'($urandom_range(0, 1))));
      end
    end
    put_item(mk_in(ACT_ENABLE, 0, 0, ($urandom_range(0, 4) != 0)));
    if ($urandom_range(0, 3) != 0) put_item(mk_in(ACT_ACK, 0, 0, 0));
    if (tm == 6'd0) begin
      pm = MIN_LAST;
      ph = (th == 5'd0) ? HOUR_LAST : th - 5'd1;
    end else begin
      pm = tm - 6'd1;
      ph = th;
    end
    put_item(mk_in(ACT_SET_TIME, ph, pm, 1'($urandom_range(0, 1))));
    for (int i = 0; i < 60 + $urandom_range(0, 3); i++) begin
      if ($urandom_range(0, 39) == 0) put_noise();
      put_item(mk_in(ACT_TICK, 5'($urandom_range(0, 31)), 6'($urandom_range(0, 63)),
                     1'($urandom_range(0, 1))));
    end
  endtask

  task automatic cmp(input string name, input logic [7:0] want, input logic [7:0] got);
    if (want !== got) begin
      errs++;
      if (errs <= 100) $error("%s: expected %0d, got %0d", name, want, got);
    end
  endtask

  always @(posedge clk) begin
    out_item_t want;
    if (rst_n && out_valid && !out_stall) begin
      readings_seen++;
      if (out_item.alarm_fired === 1'b1) alarms_rung++;
      if (pending_readings.size() == 0) begin
        errs++;
        $error("result item arrived with no expected item waiting");
      end else begin
        want = pending_readings.pop_front();
        cmp("hour_now", 8'(want.hour_now), 8'(out_item.hour_now));
        cmp("minute_now", 8'(want.minute_now), 8'(out_item.minute_now));
        cmp("second_now", 8'(want.second_now), 8'(out_item.second_now));
        cmp("alarm_fired", 8'(want.alarm_fired), 8'(out_item.alarm_fired));
        cmp("fired_index", 8'(want.fired_index), 8'(out_item.fired_index));
        cmp("ringing_now", 8'(want.ringing_now), 8'(out_item.ringing_now));
        cmp("alarms_used", 8'(want.alarms_used), 8'(out_item.alarms_used));
        cmp("heartbeat", 8'(want.heartbeat), 8'(out_item.heartbeat));
      end
    end
  end

  // Result side: random hold-offs per item, quiet stretches, and one long hold that
  // backs the block up into its input.
  initial begin
    int hold;
    int seen;
    seen = 0;
    out_stall = 1'b0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      if (seen == 300) begin
        out_stall <= 1'b1;
        repeat (250) @(posedge clk);
        out_stall <= 1'b0;
      end else begin
        hold = ((seen % 256) >= 180) ? 0 : $urandom_range(0, 15);
        if (hold > 0) begin
          out_stall <= 1'b1;
          repeat (hold) @(posedge clk);
          out_stall <= 1'b0;
        end
      end
      @(posedge clk);
      while (!(out_valid && !out_stall)) @(posedge clk);
      seen++;
    end
  end

  initial begin
    #2_000_000;
    $display("tb_time_of_day_clock_with_alarm_table_unit: FAIL");
    $finish;
  end

  initial begin
    int wait_cnt;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_item = '0;
    hour_q = '0;
    min_q = '0;
    sec_q = '0;
    alarm_cnt = '0;
    alarms_en = 1'b1;
    ring_q = 1'b0;
    for (int i = 0; i < ALARM_SLOTS_DEF; i++) alarm_tab[i] = '0;

    dir_tab[0]  = '{mk_in(ACT_TICK, 0, 0, 0), 1'b1, mk_out(0, 0, 1, 0, 0, 0, 0, 1)};
    dir_tab[1]  = '{mk_in(ACT_TICK, 0, 0, 1), 1'b1, mk_out(0, 0, 2, 0, 0, 0, 0, 0)};
    dir_tab[2]  = '{mk_in(ACT_SET_TIME, 23, 59, 0), 1'b1, mk_out(23, 59, 0, 0, 0, 0, 0, 0)};
    dir_tab[3]  = '{mk_in(ACT_ADD, 0, 0, 0), 1'b1, mk_out(23, 59, 0, 0, 0, 0, 1, 0)};
    dir_tab[4]  = '{mk_in(ACT_ADD, 31, 63, 1), 1'b1, mk_out(23, 59, 0, 0, 0, 0, 2, 0)};
    dir_tab[5]  = '{mk_in(ACT_ADD, 23, 59, 0), 1'b1, mk_out(23, 59, 0, 0, 0, 0, 3, 0)};
    dir_tab[6]  = '{mk_in(ACT_ADD, 12, 30, 0), 1'b0, '0};
    dir_tab[7]  = '{mk_in(ACT_ADD, 1, 1, 1), 1'b0, '0};
    dir_tab[8]  = '{mk_in(ACT_ADD, 22, 58, 0), 1'b0, '0};
    dir_tab[9]  = '{mk_in(ACT_ADD, 16, 0, 1), 1'b0, '0};
    dir_tab[10] = '{mk_in(ACT_ADD, 24, 60, 0), 1'b0, '0};
    dir_tab[11] = '{mk_in(ACT_ADD, 5, 45, 1), 1'b0, '0};
    dir_tab[12] = '{mk_in(ACT_ADD, 10, 10, 0), 1'b0, '0};
    dir_tab[13] = '{mk_in(ACT_ADD, 21, 15, 0), 1'b1, mk_out(23, 59, 0, 0, 0, 0, 10, 0)};
    dir_tab[14] = '{mk_in(ACT_ENABLE, 0, 0, 0), 1'b1, mk_out(23, 59, 0, 0, 0, 0, 10, 0)};
    dir_tab[15] = '{mk_in(ACT_ENABLE, 0, 0, 1), 1'b1, mk_out(23, 59, 0, 0, 0, 0, 10, 0)};
    dir_tab[16] = '{mk_in(ACT_ACK, 0, 0, 0), 1'b1, mk_out(23, 59, 0, 0, 0, 0, 10, 0)};
    dir_tab[17] = '{mk_in(ACT_SPARE6, 31, 63, 1), 1'b1, mk_out(23, 59, 0, 0, 0, 0, 10, 0)};
    dir_tab[18] = '{mk_in(ACT_SPARE7, 0, 0, 0), 1'b1, mk_out(23, 59, 0, 0, 0, 0, 10, 0)};
    dir_tab[19] = '{mk_in(ACT_SET_TIME, 31, 63, 0), 1'b1, mk_out(7, 3, 0, 0, 0, 0, 10, 0)};
    dir_tab[20] = '{mk_in(ACT_TICK, 31, 63, 1), 1'b1, mk_out(7, 3, 1, 0, 0, 0, 10, 1)};
    dir_tab[21] = '{mk_in(ACT_CLEAR, 0, 0, 0), 1'b1, mk_out(7, 3, 1, 0, 0, 0, 0, 0)};
    dir_tab[22] = '{mk_in(ACT_TICK, 0, 0, 0), 1'b1, mk_out(7, 3, 2, 0, 0, 0, 0, 0)};
    dir_tab[23] = '{mk_in(ACT_SET_TIME, 0, 0, 0), 1'b1, mk_out(0, 0, 0, 0, 0, 0, 0, 0)};
    dir_tab[24] = '{mk_in(ACT_ADD, 24, 60, 1), 1'b1, mk_out(0, 0, 0, 0, 0, 0, 1, 0)};

    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    for (int i = 0; i < N_DIR; i++) put_item(dir_tab[i].it, dir_tab[i].typed, dir_tab[i].res);

    while (items_sent < N_DIR + N_RAND) begin
      if ($urandom_range(0, 99) < 65) begin
        run_alarm_scene();
      end else begin
        for (int i = $urandom_range(5, 25); i > 0; i--) put_noise();
      end
    end
    in_valid <= 1'b0;

    wait_cnt = 0;
    while (pending_readings.size() != 0 && wait_cnt < 5000) begin
      @(posedge clk);
      wait_cnt++;
    end
    repeat (20) @(posedge clk);
    if (pending_readings.size() != 0) begin
      errs++;
      $error("%0d expected result items never arrived", pending_readings.size());
    end

    $display("Sent %0d items (%0d directed) and checked %0d result items.",
             items_sent, N_DIR, readings_seen);
    $display("Alarms started ringing %0d times; %0d mismatches.", alarms_rung, errs);
    if (errs == 0) begin
      $display("tb_time_of_day_clock_with_alarm_table_unit: PASS");
    end else begin
      $display("tb_time_of_day_clock_with_alarm_table_unit: FAIL");
    end
    $finish;
  end

endmodule
